// ===== src/cbo_pkg.sv =====
// cbo_pkg: shared types, widths and the arctangent table for the bearing core
// used by every module of the core; depends on nothing

package cbo_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int VEC_W      = 35;
	localparam int ANG_W      = 32;
	localparam int TABLE_LEN  = 24;
	localparam int ATAN_W     = 30;
	localparam int BEAR_W     = 16;
	localparam int QANG_W     = 14;

	localparam logic [BEAR_W-1:0] BEAR_QUARTER = 16'd9000;
	localparam logic [BEAR_W-1:0] BEAR_HALF    = 16'd18000;
	localparam logic [BEAR_W-1:0] BEAR_THREEQ  = 16'd27000;
	localparam logic [BEAR_W-1:0] BEAR_FULL    = 16'd36000;
	localparam logic [BEAR_W-1:0] BEAR_ZERO    = 16'd0;

	// quarter turn in 2^-16 centidegree units
	localparam logic signed [ANG_W-1:0] QUARTER_UNITS = 32'sd589824000;
	localparam logic signed [ANG_W-1:0] ROUND_HALF    = 32'sd32768;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	typedef enum logic [3:0] {
		REG_ORIGIN = 4'd0,
		REG_Q1     = 4'd1,
		REG_Q2     = 4'd2,
		REG_Q3     = 4'd3,
		REG_Q4     = 4'd4,
		REG_POS_X  = 4'd5,
		REG_POS_Y  = 4'd6,
		REG_NEG_X  = 4'd7,
		REG_NEG_Y  = 4'd8
	} region_t;

	// sideband that travels down the pipe with each request
	typedef struct packed {
		logic              valid;
		region_t           region;
		logic              use_angle;
		logic [BEAR_W-1:0] base;
	} tag_t;

	// atan(2^-i) in 2^-16 centidegree units, rounded to nearest
	localparam logic [ATAN_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
		30'd294912000, 30'd174096719, 30'd91987925, 30'd46694507,
		30'd23437865,  30'd11730358,  30'd5866610,  30'd2933484,
		30'd1466764,   30'd733385,    30'd366693,   30'd183346,
		30'd91673,     30'd45837,     30'd22918,    30'd11459,
		30'd5730,      30'd2865,      30'd1432,     30'd716,
		30'd358,       30'd179,       30'd90,       30'd45
	};

endpackage

// ===== src/cbo_prep.sv =====
// cbo_prep: first stage, classifies the position and loads the rotation vector
// depends on cbo_pkg

module cbo_prep import cbo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  logic signed [15:0]  x_cm,
	input  logic signed [15:0]  y_cm,
	output vec_t                vx_s1,
	output vec_t                vy_s1,
	output tag_t                tag_s1
);

	logic [16:0] ax, ay, adj, opp;
	tag_t        tag_d;

	assign ax = x_cm[15] ? 17'(-{x_cm[15], x_cm}) : {1'b0, x_cm};
	assign ay = y_cm[15] ? 17'(-{y_cm[15], y_cm}) : {1'b0, y_cm};

	always_comb begin
		tag_d.valid     = valid;
		tag_d.use_angle = 1'b0;
		adj             = '0;
		opp             = '0;
		priority if (x_cm == 16'sd0 && y_cm == 16'sd0) begin
			tag_d.region = REG_ORIGIN;
			tag_d.base   = BEAR_ZERO;
		end else if (y_cm == 16'sd0) begin
			tag_d.region = x_cm[15] ? REG_NEG_X : REG_POS_X;
			tag_d.base   = x_cm[15] ? BEAR_THREEQ : BEAR_QUARTER;
		end else if (x_cm == 16'sd0) begin
			tag_d.region = y_cm[15] ? REG_NEG_Y : REG_POS_Y;
			tag_d.base   = y_cm[15] ? BEAR_HALF : BEAR_ZERO;
		end else begin
			tag_d.use_angle = 1'b1;
			unique case ({x_cm[15], y_cm[15]})
				2'b00: begin
					tag_d.region = REG_Q1; tag_d.base = BEAR_ZERO;
					adj = ay; opp = ax;
				end
				2'b10: begin
					tag_d.region = REG_Q2; tag_d.base = BEAR_THREEQ;
					adj = ax; opp = ay;
				end
				2'b11: begin
					tag_d.region = REG_Q3; tag_d.base = BEAR_HALF;
					adj = ay; opp = ax;
				end
				default: begin
					tag_d.region = REG_Q4; tag_d.base = BEAR_QUARTER;
					adj = ax; opp = ay;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_d;
		end
	end

	always_ff @(posedge clk) begin
		vx_s1 <= vec_t'({{(VEC_W-17){1'b0}}, adj} << FRAC_BITS);
		vy_s1 <= vec_t'({{(VEC_W-17){1'b0}}, opp} << FRAC_BITS);
	end

endmodule

// ===== src/cbo_cordic_stage.sv =====
// cbo_cordic_stage: one registered vectoring rotation step
// depends on cbo_pkg

module cbo_cordic_stage import cbo_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  vec_t vx,
	input  vec_t vy,
	input  ang_t z,
	input  tag_t tag,
	output vec_t vx_s1,
	output vec_t vy_s1,
	output ang_t z_s1,
	output tag_t tag_s1
);

	localparam ang_t STEP_ANGLE = ang_t'({{(ANG_W-ATAN_W){1'b0}}, ATAN_TABLE[STEP]});

	vec_t dx, dy;

	// arithmetic shift is floor division, negative values included
	assign dx = vy >>> STEP;
	assign dy = vx >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		if (!vy[VEC_W-1]) begin
			vx_s1 <= vx + dx;
			vy_s1 <= vy - dy;
			z_s1  <= z + STEP_ANGLE;
		end else begin
			vx_s1 <= vx - dx;
			vy_s1 <= vy + dy;
			z_s1  <= z - STEP_ANGLE;
		end
	end

endmodule

// ===== src/cbo_post.sv =====
// cbo_post: saturates and rounds the angle, adds the quadrant offset, wraps
// depends on cbo_pkg

module cbo_post import cbo_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ang_t              z,
	input  tag_t              tag,
	output logic [BEAR_W-1:0] bearing_s2,
	output region_t           region_s2,
	output logic              valid_s2
);

	ang_t              z_sat;
	ang_t              z_rnd;
	logic [QANG_W-1:0] angle_s1;
	tag_t              tag_s1;
	logic [BEAR_W-1:0] sum;

	always_comb begin
		priority if (z[ANG_W-1]) begin
			z_sat = '0;
		end else if (z > QUARTER_UNITS) begin
			z_sat = QUARTER_UNITS;
		end else begin
			z_sat = z;
		end
	end

	assign z_rnd = (z_sat + ROUND_HALF) >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			tag_s1   <= tag;
			valid_s2 <= tag_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		angle_s1 <= z_rnd[QANG_W-1:0];
	end

	assign sum = tag_s1.base
		+ (tag_s1.use_angle ? {{(BEAR_W-QANG_W){1'b0}}, angle_s1} : BEAR_ZERO);

	always_ff @(posedge clk) begin
		bearing_s2 <= (sum >= BEAR_FULL) ? sum - BEAR_FULL : sum;
		region_s2  <= tag_s1.region;
	end

endmodule

// ===== src/compass_bearing_from_origin_core.sv =====
// compass_bearing_from_origin_core: top level of the bearing core
// depends on cbo_pkg, cbo_prep, cbo_cordic_stage and cbo_post
//
//  channel   | handshake         | payload
//  ----------+-------------------+---------------------------------
//  request   | start / busy      | x_cm, y_cm (signed cm)
//  result    | done (one cycle)  | bearing_centideg, region
//
// one request per cycle is taken; busy stays low because nothing downstream
// can hold the pipe. the pipe is one classify stage, one stage per rotation
// step of the vectoring chain, then saturate/round and offset/wrap stages;
// the rotation chain sets the depth.
// reset clears every valid bit at once; no clearing pass is needed.
// results cannot be stalled, so each shows on the ports for one cycle only

module compass_bearing_from_origin_core import cbo_pkg::*; #(
	parameter int ANGLE_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] x_cm,
	input  logic signed [15:0] y_cm,
	output logic               done,
	output logic [15:0]        bearing_centideg,
	output logic [3:0]         region
);

	// rotation steps stop at the end of the table
	localparam int STEPS = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;

	vec_t    chain_vx  [STEPS+1];
	vec_t    chain_vy  [STEPS+1];
	ang_t    chain_z   [STEPS+1];
	tag_t    chain_tag [STEPS+1];
	region_t region_out;

	// the pipe never stalls, so requests are always welcome
	assign busy = 1'b0;

	// classify position, take magnitudes, load the vector
	cbo_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (start & ~busy),
		.x_cm   (x_cm),
		.y_cm   (y_cm),
		.vx_s1  (chain_vx[0]),
		.vy_s1  (chain_vy[0]),
		.tag_s1 (chain_tag[0])
	);

	// angle accumulator starts at zero for every request
	assign chain_z[0] = '0;

	// one register stage per rotation step
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		cbo_cordic_stage #(
			.STEP (i)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.vx     (chain_vx[i]),
			.vy     (chain_vy[i]),
			.z      (chain_z[i]),
			.tag    (chain_tag[i]),
			.vx_s1  (chain_vx[i+1]),
			.vy_s1  (chain_vy[i+1]),
			.z_s1   (chain_z[i+1]),
			.tag_s1 (chain_tag[i+1])
		);
	end

	// saturate, round, add quadrant offset, wrap the full turn
	cbo_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.z          (chain_z[STEPS]),
		.tag        (chain_tag[STEPS]),
		.bearing_s2 (bearing_centideg),
		.region_s2  (region_out),
		.valid_s2   (done)
	);

	assign region = region_out;

endmodule
